// ===== sv/char_lcd_4bit_interface_sequencer_defines.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef CHAR_LCD_4BIT_INTERFACE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_4BIT_INTERFACE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define CLCD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define CLCD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CLCD_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define CLCD_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/clcd_pkg.sv =====
package clcd_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_BITS   = 16;
	localparam int WAIT_BITS  = 13;
	localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
	localparam logic [CFG_BITS-1:0]   PULSE_RESET = 16'd1000;
	localparam logic [3:0]            INIT_STEPS = 4'd14;
	localparam logic [3:0]            CHAR_STEPS = 4'd2;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_INIT  = 2'd1,
		KIND_CHAR  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2,
		PH_WAIT = 2'd3
	} phase_t;

	typedef struct packed {
		logic       rs;
		logic       en;
		logic [3:0] nibble;
		logic       busy;
		logic       rej;
	} res_t;

	function automatic logic [3:0] init_nibble(input logic [3:0] idx);
		logic [3:0] n;
		unique case (idx)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3, 4'd4:       n = 4'h2;
			4'd5, 4'd7:       n = 4'h8;
			4'd9:             n = 4'h1;
			4'd11:            n = 4'h6;
			4'd13:            n = 4'hF;
			default:          n = 4'h0;
		endcase
		return n;
	endfunction

	// wait after each init nibble, in us
	function automatic logic [WAIT_BITS-1:0] init_wait(input logic [3:0] idx);
		logic [WAIT_BITS-1:0] w;
		unique case (idx)
			4'd0:                           w = 13'd5000;
			4'd1, 4'd2, 4'd5, 4'd7, 4'd11:  w = 13'd128;
			4'd3:                           w = 13'd1000;
			4'd9, 4'd13:                    w = 13'd64;
			default:                        w = 13'd0;
		endcase
		return w;
	endfunction

endpackage

// ===== sv/clcd_seq_core.sv =====
`include "char_lcd_4bit_interface_sequencer_defines.svh"

module clcd_seq_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  clcd_pkg::kind_t               kind,
	input  logic [7:0]                    code,
	input  logic [clcd_pkg::CFG_BITS-1:0] pulse_us,
	output clcd_pkg::res_t                res
);
	import clcd_pkg::*;

	phase_t                phase_q, phase_d;
	logic [3:0]            step_q, step_d;
	logic [TIMER_BITS-1:0] tick_q, tick_d;
	logic                  init_q, init_d;
	logic [7:0]            latch_q, latch_d;
	logic                  rs_q, rs_d;
	logic                  en_q, en_d;
	logic [3:0]            nib_q, nib_d;

	logic                  is_cmd, is_tick, start_cmd, done, finish, wait_nz;
	logic [TIMER_BITS-1:0] tick_inc;
	logic [CMP_BITS-1:0]   target;
	logic [3:0]            step_inc, last;
	logic [3:0]            step_nib;
	logic [WAIT_BITS-1:0]  wait_cur;

	always_comb begin
		is_cmd    = (kind != KIND_TICK);
		is_tick   = adv && !is_cmd;
		start_cmd = adv && is_cmd && (phase_q == PH_IDLE);
		tick_inc  = (tick_q != TIMER_MAX) ? tick_q + 1'b1 : tick_q;
		wait_cur  = init_q ? init_wait(step_q) : '0;
		wait_nz   = (wait_cur != '0);
		target    = (phase_q == PH_WAIT) ? CMP_BITS'(wait_cur) : CMP_BITS'(pulse_us);
		done      = (CMP_BITS'(tick_inc) >= target) || (tick_inc == TIMER_MAX);
		step_inc  = step_q + 4'd1;
		last      = init_q ? INIT_STEPS : CHAR_STEPS;
		finish    = (step_inc >= last);
		if (init_q)
			step_nib = init_nibble(step_inc);
		else
			step_nib = (step_inc == 4'd0) ? latch_q[7:4] : latch_q[3:0];
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: if (start_cmd) phase_d = PH_HIGH;
			PH_HIGH: if (is_tick && done) phase_d = PH_LOW;
			PH_LOW: begin
				if (is_tick && done) begin
					if (wait_nz)
						phase_d = PH_WAIT;
					else
						phase_d = finish ? PH_IDLE : PH_HIGH;
				end
			end
			PH_WAIT: if (is_tick && done) phase_d = finish ? PH_IDLE : PH_HIGH;
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		logic nxt;
		step_d  = step_q;
		tick_d  = tick_q;
		init_d  = init_q;
		latch_d = latch_q;
		rs_d    = rs_q;
		en_d    = en_q;
		nib_d   = nib_q;
		nxt     = 1'b0;
		if (start_cmd) begin
			step_d = 4'd0;
			tick_d = '0;
			en_d   = 1'b1;
			if (kind == KIND_CHAR) begin
				init_d  = 1'b0;
				latch_d = code;
				nib_d   = code[7:4];
			end else begin
				init_d = 1'b1;
				rs_d   = 1'b0;
				nib_d  = init_nibble(4'd0);
			end
		end else if (is_tick && phase_q != PH_IDLE) begin
			tick_d = tick_inc;
			if (done) begin
				tick_d = '0;
				case (phase_q)
					PH_HIGH: en_d = 1'b0;
					PH_LOW:  nxt = !wait_nz;
					PH_WAIT: nxt = 1'b1;
					default: nxt = 1'b0;
				endcase
			end
		end
		if (nxt) begin
			if (finish) begin
				step_d = 4'd0;
				if (init_q)
					rs_d = 1'b1;
			end else begin
				step_d = step_inc;
				nib_d  = step_nib;
				en_d   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			tick_q  <= '0;
			init_q  <= 1'b0;
			latch_q <= '0;
			rs_q    <= 1'b0;
			en_q    <= 1'b0;
			nib_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			step_q  <= step_d;
			tick_q  <= tick_d;
			init_q  <= init_d;
			latch_q <= latch_d;
			rs_q    <= rs_d;
			en_q    <= en_d;
			nib_q   <= nib_d;
		end
	end

	always_comb begin
		res.rs     = rs_d;
		res.en     = en_d;
		res.nibble = nib_d;
		res.busy   = (phase_d != PH_IDLE);
		res.rej    = adv && is_cmd && (phase_q != PH_IDLE);
	end

	`CLCD_ASSERT_IMPL(a_en_in_high, clk, arst_n, 1'b1, en_q == (phase_q == PH_HIGH))
	`CLCD_ASSERT_IMPL(a_step_range, clk, arst_n, 1'b1, step_q < INIT_STEPS)
	`CLCD_ASSERT_IMPL(a_idle_timer, clk, arst_n, phase_q == PH_IDLE, tick_q == '0)

endmodule

// ===== sv/char_lcd_4bit_interface_sequencer.sv =====
// Channel   Handshake              Payload
// cmd       cmd_valid / cmd_stall  kind, char_code
// res       res_valid / res_stall  rs_pin, enable_pin, data_nibble, busy_res, rejected
// cfg       cfg_we                 cfg_data (pulse_us)
//
// One transaction per cycle sustained while res_stall is low; a result passes through
// the input register, then the result register behind the sequencer logic.
// arst_n clears the sequencer state, pipeline valids and sets pulse_us to 1000.
// A stalled result holds the result register; the input register then fills and
// cmd_stall rises until the result is taken.
`include "char_lcd_4bit_interface_sequencer_defines.svh"

module char_lcd_4bit_interface_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [1:0]                    kind,
	input  logic [7:0]                    char_code,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          rs_pin,
	output logic                          enable_pin,
	output logic [3:0]                    data_nibble,
	output logic                          busy_res,
	output logic                          rejected,
	input  logic                          cfg_we,
	input  logic [clcd_pkg::CFG_BITS-1:0] cfg_data
);
	import clcd_pkg::*;

	logic                vld_s1;
	kind_t               kind_s1;
	logic [7:0]          code_s1;
	logic                res_valid_q;
	res_t                res_q, res_next;
	logic [CFG_BITS-1:0] pulse_q;
	logic                advance, cmd_take;

	assign advance   = vld_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = vld_s1 && !advance;
	assign cmd_take  = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pulse_q <= PULSE_RESET;
		else if (cfg_we)
			pulse_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (cmd_take)
			vld_s1 <= 1'b1;
		else if (advance)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			kind_s1 <= kind_t'(kind);
			code_s1 <= char_code;
		end
	end

	clcd_seq_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (advance),
		.kind     (kind_s1),
		.code     (code_s1),
		.pulse_us (pulse_q),
		.res      (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_next;
	end

	assign res_valid   = res_valid_q;
	assign rs_pin      = res_q.rs;
	assign enable_pin  = res_q.en;
	assign data_nibble = res_q.nibble;
	assign busy_res    = res_q.busy;
	assign rejected    = res_q.rej;

	`CLCD_ASSERT_NEXT(a_s1_holds, clk, arst_n, vld_s1 && !advance, vld_s1)
	`CLCD_ASSERT_IMPL(a_rej_busy, clk, arst_n, res_valid_q && res_q.rej, res_q.busy)

endmodule

// ===== bench/char_lcd_4bit_interface_sequencer_check.sv =====
`timescale 1ns / 100ps

module char_lcd_4bit_interface_sequencer_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  logic                          cmd_stall,
	input  logic [1:0]                    kind,
	input  logic [7:0]                    char_code,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic                          rs_pin,
	input  logic                          enable_pin,
	input  logic [3:0]                    data_nibble,
	input  logic                          busy_res,
	input  logic                          rejected,
	input  logic                          cfg_we,
	input  logic [clcd_pkg::CFG_BITS-1:0] cfg_data,
	output int                            fail_count,
	output int                            pending,
	output logic                          lcd_busy
);
	import clcd_pkg::*;

	// init nibbles, step 0 in the low digit
	localparam logic [55:0] SEQ_NIBBLES = 56'hF0601080822333;

	res_t pin_q[$];
	res_t want;
	res_t made;
	int   errors;

	logic [CFG_BITS-1:0]   pulse;
	phase_t                ph;
	logic [3:0]            step;
	logic [TIMER_BITS-1:0] ticks;
	logic                  init_mode;
	logic [7:0]            latch;
	logic                  rs;
	logic                  en;
	logic [3:0]            nib;

	function automatic logic [12:0] hold_time(input logic [3:0] idx);
		logic [12:0] w;
		if (!init_mode) begin
			return 13'd0;
		end
		case (idx)
			4'd0: w = 13'd5000;
			4'd1, 4'd2, 4'd5, 4'd7, 4'd11: w = 13'd128;
			4'd3: w = 13'd1000;
			4'd9, 4'd13: w = 13'd64;
			default: w = 13'd0;
		endcase
		return w;
	endfunction

	task automatic load_nibble();
		if (init_mode) begin
			nib = SEQ_NIBBLES[{step, 2'b00} +: 4];
		end else begin
			nib = (step == 4'd0) ? latch[7:4] : latch[3:0];
		end
		en = 1'b1;
		ticks = '0;
		ph = PH_HIGH;
	endtask

	task automatic next_nibble();
		logic [3:0] last;
		last = init_mode ? INIT_STEPS : CHAR_STEPS;
		step = step + 4'd1;
		if (step >= last) begin
			if (init_mode) begin
				rs = 1'b1;
			end
			step = '0;
			ticks = '0;
			ph = PH_IDLE;
		end else begin
			load_nibble();
		end
	endtask

	// saturating count, the top value also ends the phase
	task automatic count_tick(input logic [TIMER_BITS-1:0] target, output logic done);
		if (ticks != TIMER_MAX) begin
			ticks = ticks + 1'b1;
		end
		done = (ticks >= target) || (ticks == TIMER_MAX);
	endtask

	task automatic apply_item(input logic [1:0] k, input logic [7:0] code, output res_t r);
		logic done;
		logic rej;
		rej = 1'b0;
		if (k == KIND_TICK) begin
			case (ph)
				PH_HIGH: begin
					count_tick(pulse, done);
					if (done) begin
						en = 1'b0;
						ticks = '0;
						ph = PH_LOW;
					end
				end
				PH_LOW: begin
					count_tick(pulse, done);
					if (done) begin
						ticks = '0;
						if (hold_time(step) != 13'd0) begin
							ph = PH_WAIT;
						end else begin
							next_nibble();
						end
					end
				end
				PH_WAIT: begin
					count_tick(TIMER_BITS'(hold_time(step)), done);
					if (done) begin
						next_nibble();
					end
				end
				default: ;
			endcase
		end else if (ph != PH_IDLE) begin
			rej = 1'b1;
		end else begin
			step = '0;
			if (k == KIND_CHAR) begin
				init_mode = 1'b0;
				latch = code;
			end else begin
				init_mode = 1'b1;
				rs = 1'b0;
			end
			load_nibble();
		end
		r.rs = rs;
		r.en = en;
		r.nibble = nib;
		r.busy = (ph != PH_IDLE);
		r.rej = rej;
	endtask

	task automatic check_field(input string name, input logic [3:0] exp_v, input logic [3:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse = PULSE_RESET;
			ph = PH_IDLE;
			step = '0;
			ticks = '0;
			init_mode = 1'b0;
			latch = '0;
			rs = 1'b0;
			en = 1'b0;
			nib = '0;
			pin_q.delete();
			errors = 0;
			pending <= 0;
			lcd_busy <= 1'b0;
			fail_count <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pin_q.size() == 0) begin
					errors++;
					$display("%0t: result with no transaction pending, rs %0d en %0d nibble %0d",
						$time, rs_pin, enable_pin, data_nibble);
				end else begin
					want = pin_q.pop_front();
					check_field("rs_pin", 4'(want.rs), 4'(rs_pin));
					check_field("enable_pin", 4'(want.en), 4'(enable_pin));
					check_field("data_nibble", want.nibble, data_nibble);
					check_field("busy_res", 4'(want.busy), 4'(busy_res));
					check_field("rejected", 4'(want.rej), 4'(rejected));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				apply_item(kind, char_code, made);
				pin_q.push_back(made);
			end
			if (cfg_we) begin
				pulse = cfg_data;
			end
			pending <= pin_q.size();
			lcd_busy <= (ph != PH_IDLE);
			fail_count <= errors;
		end
	end

endmodule

// ===== bench/char_lcd_4bit_interface_sequencer_test.sv =====
`timescale 1ns / 100ps

module char_lcd_4bit_interface_sequencer_test;
	import clcd_pkg::*;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	logic [1:0]          kind = KIND_TICK;
	logic [7:0]          char_code = 8'h00;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic                rs_pin;
	logic                enable_pin;
	logic [3:0]          data_nibble;
	logic                busy_res;
	logic                rejected;
	logic                cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	int   fail_count;
	int   pending;
	logic lcd_busy;

	bit quiet = 1'b0;
	int burst_left = 0;
	int items_sent = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;

	char_lcd_4bit_interface_sequencer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.kind       (kind),
		.char_code  (char_code),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.rs_pin     (rs_pin),
		.enable_pin (enable_pin),
		.data_nibble(data_nibble),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	char_lcd_4bit_interface_sequencer_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.kind       (kind),
		.char_code  (char_code),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.rs_pin     (rs_pin),
		.enable_pin (enable_pin),
		.data_nibble(data_nibble),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.lcd_busy   (lcd_busy)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("char_lcd_4bit_interface_sequencer_test: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(16, 300);
		end else begin
			mode_left--;
		end
		stall_phase++;
		if (quiet) begin
			res_stall <= 1'b0;
		end else begin
			case (stall_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 7) == 0);
				2: res_stall <= 1'($urandom_range(0, 1));
				default: res_stall <= (stall_phase % 3 == 0);
			endcase
		end
	end

	// one transaction, with a gap between bursts
	task automatic send(input kind_t k, input logic [7:0] code);
		int gap;
		if (burst_left == 0 && !quiet) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end else if (burst_left > 0) begin
			burst_left--;
		end
		cmd_valid <= 1'b1;
		kind <= k;
		char_code <= code;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		items_sent++;
	endtask

	// ticks, with occasional characters when inject is set, until the display is idle; ends only after a tick
	task automatic settle(input bit inject);
		bit last_tick;
		do begin
			if (inject && $urandom_range(0, 39) == 0) begin
				send(KIND_CHAR, 8'($urandom_range(0, 255)));
				last_tick = 1'b0;
			end else begin
				send(KIND_TICK, 8'($urandom_range(0, 255)));
				last_tick = 1'b1;
			end
		end while (lcd_busy || !last_tick);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pulse(input logic [CFG_BITS-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int r;
		int n;
		int start;
		int value;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pulse width, character before any init, commands while busy
		send(KIND_TICK, 8'hFF);
		send(KIND_CHAR, 8'hA5);
		send(KIND_INIT, 8'h00);
		send(KIND_CLEAR, 8'hFF);
		send(KIND_CHAR, 8'h00);
		repeat (40) send(KIND_TICK, 8'h00);

		// pulse width shortened in the middle of a transfer
		write_pulse(16'd1);
		settle(1'b0);
		send(KIND_CHAR, 8'hFF);
		settle(1'b0);
		send(KIND_CHAR, 8'h00);
		settle(1'b0);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: value = $urandom_range(2, 12);
				1: value = 3;
				2: value = $urandom_range(1, 40);
				default: value = 2;
			endcase
			write_pulse(value[CFG_BITS-1:0]);
			start = items_sent;
			while (items_sent - start < 280) begin
				quiet = ($urandom_range(0, 7) == 0);
				r = $urandom_range(0, 99);
				if (r < 75) begin
					send(KIND_CHAR, 8'($urandom_range(0, 255)));
					settle(1'b1);
				end else if (r < 85) begin
					send(KIND_CHAR, 8'($urandom_range(0, 255)));
					send(kind_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
					settle(1'b1);
				end else begin
					n = $urandom_range(1, 4);
					repeat (n) send(KIND_TICK, 8'($urandom_range(0, 255)));
					settle(1'b0);
				end
			end
		end
		quiet = 1'b0;

		// init: first nibble, then into its long wait, commands rejected
		write_pulse(16'd1);
		send(KIND_INIT, 8'h00);
		repeat (60) send(KIND_TICK, 8'($urandom_range(0, 255)));
		send(KIND_CHAR, 8'h3C);
		send(KIND_CLEAR, 8'h00);
		send(KIND_INIT, 8'h00);
		repeat (60) send(KIND_TICK, 8'($urandom_range(0, 255)));

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("char_lcd_4bit_interface_sequencer_test: PASS");
		end else begin
			$display("char_lcd_4bit_interface_sequencer_test: FAIL");
		end
		$finish;
	end

endmodule
